// File: hw/rtl/toq_pkg.sv
package toq_pkg;

   // default store depth
   localparam int TOQ_CAPACITY = 16;

   // field widths
   localparam int KIND_W   = 2;
   localparam int STAMP_W  = 31;
   localparam int PROC_W   = 10;
   localparam int AMOUNT_W = 16;
   localparam int DOCK_W   = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int SUM_W    = 20;
   localparam int OCC_W    = 5;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

   // cell commands
   localparam int CELL_OP_W = 2;
   localparam logic [CELL_OP_W-1:0] CELL_HOLD   = 2'd0;
   localparam logic [CELL_OP_W-1:0] CELL_INSERT = 2'd1;
   localparam logic [CELL_OP_W-1:0] CELL_REMOVE = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [STAMP_W-1:0]  stamp;
      logic [PROC_W-1:0]   proc_id;
      logic [AMOUNT_W-1:0] amount;
      logic [DOCK_W-1:0]   dock_num;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  ahead_count;
      logic [SUM_W-1:0]    ahead_sum;
      logic [AMOUNT_W-1:0] found_amount;
      logic [DOCK_W-1:0]   found_dock;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // one stored request
   typedef struct packed {
      logic [STAMP_W-1:0]  stamp;
      logic [PROC_W-1:0]   proc_id;
      logic [AMOUNT_W-1:0] amount;
      logic [DOCK_W-1:0]   dock_num;
   } entry_type;

   // broadcast to every cell
   typedef struct packed {
      logic [CELL_OP_W-1:0] op;
      entry_type            item;
   } cell_cmd_type;

   // per-cell status seen by neighbours and the control
   typedef struct packed {
      logic valid;
      logic lt;   // stored key orders before the new key
      logic eq;   // stored key equals the new key
   } cell_stat_type;

   // id scan travelling down the row, one cell per cycle
   typedef struct packed {
      logic                seen;
      logic [COUNT_W-1:0]  count;
      logic [SUM_W-1:0]    sum;
      logic [AMOUNT_W-1:0] famt;
      logic [DOCK_W-1:0]   fdock;
   } scan_type;

endpackage

// File: hw/rtl/toq_req_if.sv
interface toq_req_if import toq_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/toq_rsp_if.sv
interface toq_rsp_if import toq_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/toq_cell.sv
module toq_cell import toq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   input  cell_stat_type left_stat,
   input  entry_type     left_entry,
   input  scan_type      left_scan,
   input  logic          right_valid,
   input  entry_type     right_entry,
   output cell_stat_type stat,
   output entry_type     entry,
   output scan_type      scan
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   scan_type  scan_ff, scan_in;
   logic      hit;
   logic      ahead;

   assign stat.valid = valid_ff;
   assign stat.lt    = valid_ff &&
                       ({entry_ff.stamp, entry_ff.proc_id} < {cmd.item.stamp, cmd.item.proc_id});
   assign stat.eq    = valid_ff &&
                       ({entry_ff.stamp, entry_ff.proc_id} == {cmd.item.stamp, cmd.item.proc_id});
   assign entry      = entry_ff;
   assign scan       = scan_ff;

   // scan step: first id match and everything ahead of it
   always_comb begin
      hit             = valid_ff && (entry_ff.proc_id == cmd.item.proc_id);
      scan_in.seen    = left_scan.seen | hit;
      ahead           = valid_ff && !scan_in.seen;
      scan_in.count   = left_scan.count + COUNT_W'(ahead);
      scan_in.sum     = left_scan.sum + (ahead ? SUM_W'(entry_ff.amount) : SUM_W'(0));
      scan_in.famt    = left_scan.seen ? left_scan.famt  : (hit ? entry_ff.amount   : '0);
      scan_in.fdock   = left_scan.seen ? left_scan.fdock : (hit ? entry_ff.dock_num : '0);
   end

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (!stat.lt) begin
               if (left_stat.lt) begin
                  entry_in = cmd.item;
                  valid_in = 1'b1;
               end else begin
                  entry_in = left_entry;
                  valid_in = left_stat.valid;
               end
            end
         end
         CELL_REMOVE: begin
            if (scan_ff.seen) begin
               entry_in = right_entry;
               valid_in = right_valid;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
      scan_ff  <= scan_in;
   end

endmodule

// File: hw/rtl/timestamp_ordered_request_queue.sv
// Channel  Direction  Interface   Transaction
// req_chan in         toq_req_if  one insert, remove or lookup request
// rsp_chan out        toq_rsp_if  one response per request
//
// Insert and the unused kind: the request goes straight to the commit state and its
// response is registered at commit. Remove and lookup: the id scan ripples down the
// cell row, one cell per cycle, before the result is taken from the last cell at
// commit. A request is taken only once the last one has committed.
// Synchronous active-high reset empties the row (valid bits and fill count) and
// clears the control state and response valid. A new request is accepted while a
// response still waits; the next commit holds until the response register is free.
module timestamp_ordered_request_queue import toq_pkg::*; #(
   parameter int CAPACITY = TOQ_CAPACITY
) (
   input  logic clock,
   input  logic reset,
   toq_req_if.sink   req_chan,
   toq_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   // control states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   entry_type        item_ff, item_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   cell_cmd_type  cmd;
   cell_stat_type stat [CAPACITY];
   entry_type     ent  [CAPACITY];
   scan_type      scn  [CAPACITY];
   logic [CAPACITY-1:0] valid_vec;

   logic req_fire;
   logic out_free;
   logic commit;
   logic dup;
   logic full;
   logic found;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign commit   = (state_ff == ST_EXEC) && out_free;
   assign full     = (fill_ff == CNT_W'(CAPACITY));
   assign found    = scn[CAPACITY-1].seen;

   // duplicate key anywhere in the row
   always_comb begin
      dup = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         dup          = dup | stat[i].eq;
         valid_vec[i] = stat[i].valid;
      end
   end

   // row of cells; cell 0 sees an always-before neighbour on its left
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      cell_stat_type l_stat;
      entry_type     l_entry;
      scan_type      l_scan;
      logic          r_valid;
      entry_type     r_entry;

      if (g == 0) begin : g_head
         assign l_stat  = '{valid: 1'b0, lt: 1'b1, eq: 1'b0};
         assign l_entry = '0;
         assign l_scan  = '0;
      end else begin : g_mid
         assign l_stat  = stat[g-1];
         assign l_entry = ent[g-1];
         assign l_scan  = scn[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         assign r_valid = 1'b0;
         assign r_entry = '0;
      end else begin : g_body
         assign r_valid = stat[g+1].valid;
         assign r_entry = ent[g+1];
      end

      toq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_stat   (l_stat),
         .left_entry  (l_entry),
         .left_scan   (l_scan),
         .right_valid (r_valid),
         .right_entry (r_entry),
         .stat        (stat[g]),
         .entry       (ent[g]),
         .scan        (scn[g])
      );
   end

   // commit decision and response build
   always_comb begin
      cmd.item    = item_ff;
      cmd.op      = CELL_HOLD;
      fill_in     = fill_ff;
      rsp_data_in = rsp_data_ff;
      if (commit) begin
         rsp_data_in        = '0;
         rsp_data_in.status = STAT_DONE;
         case (kind_ff)
            KIND_INSERT: begin
               if (dup) begin
                  rsp_data_in.status = STAT_DUPLICATE;
               end else if (full) begin
                  rsp_data_in.status = STAT_FULL;
               end else begin
                  cmd.op  = CELL_INSERT;
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
            KIND_REMOVE: begin
               if (!found) begin
                  rsp_data_in.status = STAT_NOT_FOUND;
               end else begin
                  cmd.op  = CELL_REMOVE;
                  fill_in = fill_ff - CNT_W'(1);
               end
            end
            KIND_LOOKUP: begin
               if (!found) begin
                  rsp_data_in.status = STAT_NOT_FOUND;
               end else begin
                  rsp_data_in.ahead_count  = scn[CAPACITY-1].count;
                  rsp_data_in.ahead_sum    = scn[CAPACITY-1].sum;
                  rsp_data_in.found_amount = scn[CAPACITY-1].famt;
                  rsp_data_in.found_dock   = scn[CAPACITY-1].fdock;
               end
            end
            default: begin
            end
         endcase
         rsp_data_in.occupancy = OCC_W'(fill_in);
      end
   end

   // sequencing
   always_comb begin
      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      kind_in      = kind_ff;
      item_in      = item_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in          = req_chan.payload.kind;
               item_in.stamp    = req_chan.payload.stamp;
               item_in.proc_id  = req_chan.payload.proc_id;
               item_in.amount   = req_chan.payload.amount;
               item_in.dock_num = req_chan.payload.dock_num;
               scan_cnt_in      = '0;
               case (req_chan.payload.kind) inside
                  KIND_REMOVE, KIND_LOOKUP: state_in = ST_SCAN;
                  default:                  state_in = ST_EXEC;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff == IDX_W'(CAPACITY - 1)) begin
               state_in = ST_EXEC;
            end else begin
               scan_cnt_in = scan_cnt_ff + IDX_W'(1);
            end
         end
         ST_EXEC: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // valid bits always match the fill count
   a_fill_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(fill_ff))
      else $error("valid bits disagree with fill count");

   // fill count never passes the depth
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   // a committed insert grows the store by exactly one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == CELL_INSERT) |=> (fill_ff == CNT_W'($past(fill_ff) + CNT_W'(1))))
      else $error("insert did not grow the store");

   // no cell update is issued before the response register is free
   a_commit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == CELL_INSERT || cmd.op == CELL_REMOVE) |-> out_free)
      else $error("cell update with response slot busy");
`endif

endmodule

// File: test/toq_response_checker.sv
`timescale 1ns / 100ps

module toq_response_checker import toq_pkg::*; #(
   parameter int CAPACITY = TOQ_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      mismatches,
   output int      pending
);

   entry_type queued[$];     // stored requests, ascending (stamp, proc_id)
   rsp_type   due_rsp[$];    // responses owed by the block, oldest first
   int        bad_count = 0;

   assign mismatches = bad_count;

   function automatic bit key_before(logic [STAMP_W-1:0] sa, logic [PROC_W-1:0] pa,
                                     logic [STAMP_W-1:0] sb, logic [PROC_W-1:0] pb);
      if (sa != sb) return sa < sb;
      return pa < pb;
   endfunction

   // -1 when no stored request carries the id
   function automatic int first_with_proc(logic [PROC_W-1:0] pid);
      foreach (queued[i])
         if (queued[i].proc_id == pid) return i;
      return -1;
   endfunction

   function automatic rsp_type serve_request(req_type r);
      rsp_type         a;
      entry_type       e;
      int              pos;
      int              cnt;
      logic [31:0]     sum;
      a = '0;
      a.status = STAT_DONE;
      cnt = 0;
      sum = '0;
      case (r.kind)
         KIND_INSERT: begin
            pos = 0;
            while (pos < queued.size() && key_before(queued[pos].stamp, queued[pos].proc_id,
                                                     r.stamp, r.proc_id))
               pos++;
            if (pos < queued.size() && queued[pos].stamp == r.stamp &&
                queued[pos].proc_id == r.proc_id) begin
               a.status = STAT_DUPLICATE;
            end else if (queued.size() >= CAPACITY) begin
               a.status = STAT_FULL;
            end else begin
               e.stamp    = r.stamp;
               e.proc_id  = r.proc_id;
               e.amount   = r.amount;
               e.dock_num = r.dock_num;
               queued.insert(pos, e);
            end
         end
         KIND_REMOVE: begin
            pos = first_with_proc(r.proc_id);
            if (pos < 0) a.status = STAT_NOT_FOUND;
            else queued.delete(pos);
         end
         KIND_LOOKUP: begin
            pos = first_with_proc(r.proc_id);
            if (pos < 0) begin
               a.status = STAT_NOT_FOUND;
            end else begin
               for (int i = 0; i < pos; i++) begin
                  if (key_before(queued[i].stamp, queued[i].proc_id,
                                 queued[pos].stamp, queued[pos].proc_id)) begin
                     cnt++;
                     sum += queued[i].amount;
                  end
               end
               a.ahead_count  = COUNT_W'(cnt);
               a.ahead_sum    = SUM_W'(sum);
               a.found_amount = queued[pos].amount;
               a.found_dock   = queued[pos].dock_num;
            end
         end
         default: ;
      endcase
      a.occupancy = OCC_W'(queued.size());
      return a;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      bad_count++;
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         queued.delete();
         due_rsp.delete();
         pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_rsp.size() == 0) begin
               report_mismatch("unexpected response, occupancy", rsp_payload.occupancy, 0);
            end else begin
               want = due_rsp.pop_front();
               if (rsp_payload.status !== want.status)
                  report_mismatch("status", rsp_payload.status, want.status);
               if (rsp_payload.ahead_count !== want.ahead_count)
                  report_mismatch("ahead_count", rsp_payload.ahead_count, want.ahead_count);
               if (rsp_payload.ahead_sum !== want.ahead_sum)
                  report_mismatch("ahead_sum", rsp_payload.ahead_sum, want.ahead_sum);
               if (rsp_payload.found_amount !== want.found_amount)
                  report_mismatch("found_amount", rsp_payload.found_amount, want.found_amount);
               if (rsp_payload.found_dock !== want.found_dock)
                  report_mismatch("found_dock", rsp_payload.found_dock, want.found_dock);
               if (rsp_payload.occupancy !== want.occupancy)
                  report_mismatch("occupancy", rsp_payload.occupancy, want.occupancy);
            end
         end
         if (req_valid && req_ready)
            due_rsp.push_back(serve_request(req_payload));
         pending <= due_rsp.size();
      end
   end

endmodule

// File: test/timestamp_ordered_request_queue_tb.sv
`timescale 1ns / 100ps

module timestamp_ordered_request_queue_tb;
   import toq_pkg::*;

   // kind 3 has no name in the package; the block answers it with a plain done
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 550;
   localparam int CALM_ITEMS   = 60;                 // tail of the run with no idling
   localparam int PHASE_LEN    = 60;                 // alternate fill and drain phases
   localparam int DRAIN_CYCLES = TOQ_CAPACITY + 8;   // longest scan plus margin
   localparam int CYCLE_LIMIT  = 400000;

   logic clock;
   logic reset;
   bit   quiet = 1'b0;       // set for the final stretch: no gaps, no stalls
   int   cycle_count = 0;
   int   mismatches;
   int   pending;

   toq_req_if req_chan ();
   toq_rsp_if rsp_chan ();

   timestamp_ordered_request_queue #(
      .CAPACITY (TOQ_CAPACITY)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // watches both channels, predicts every response and counts mismatches
   toq_response_checker #(
      .CAPACITY (TOQ_CAPACITY)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_payload (req_chan.payload),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // runaway guard: a hung handshake or a lost response ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic req_type make_req(logic [KIND_W-1:0] kind, logic [STAMP_W-1:0] stamp,
                                        logic [PROC_W-1:0] pid, logic [AMOUNT_W-1:0] amount,
                                        logic [DOCK_W-1:0] dock);
      req_type r;
      r.kind     = kind;
      r.stamp    = stamp;
      r.proc_id  = pid;
      r.amount   = amount;
      r.dock_num = dock;
      return r;
   endfunction

   // Small pools of stamps and ids so that duplicates, tie-breaks on equal
   // stamps and hits on remove/lookup are common; the odd full-range value
   // keeps every bit toggling.
   function automatic req_type random_request(int insert_pct);
      req_type r;
      int      roll;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct)                          r.kind = KIND_INSERT;
      else if (roll < insert_pct + (100 - insert_pct) / 2) r.kind = KIND_REMOVE;
      else if (roll < 98)                             r.kind = KIND_LOOKUP;
      else                                            r.kind = KIND_UNUSED;
      case ($urandom_range(0, 9))
         0:       r.stamp = STAMP_W'($urandom);
         1:       r.stamp = {STAMP_W{1'b1}} - STAMP_W'($urandom_range(0, 3));
         default: r.stamp = STAMP_W'($urandom_range(0, 7));
      endcase
      case ($urandom_range(0, 9))
         0:       r.proc_id = PROC_W'($urandom_range(0, 1023));
         1:       r.proc_id = {PROC_W{1'b1}} - PROC_W'($urandom_range(0, 3));
         default: r.proc_id = PROC_W'($urandom_range(0, 7));
      endcase
      case ($urandom_range(0, 5))
         0:       r.amount = '0;
         1:       r.amount = '1;
         default: r.amount = AMOUNT_W'($urandom);
      endcase
      r.dock_num = DOCK_W'($urandom);
      return r;
   endfunction

   // Hold the request until the block takes it, then perhaps leave a gap.
   // Valid stays high into the next request when there is no gap.
   task automatic send_request(req_type r);
      req_chan.valid   <= 1'b1;
      req_chan.payload <= r;
      do @(posedge clock); while (!req_chan.ready);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // response back-pressure: bursts of stall between runs of ready
   initial begin : rsp_stall
      rsp_chan.ready <= 1'b0;
      repeat (5) @(posedge clock);
      forever begin
         rsp_chan.ready <= 1'b1;
         repeat (($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12)) @(posedge clock);
         if (!quiet && $urandom_range(0, 1) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int insert_pct;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, duplicates, tie-break on equal stamps,
      // field extremes, same id at two stamps, unused kind, missing id
      send_request(make_req(KIND_LOOKUP, 31'd9, 10'd3, 16'd0, 8'd0));
      send_request(make_req(KIND_REMOVE, 31'd9, 10'd3, 16'd0, 8'd0));
      send_request(make_req(KIND_UNUSED, '1, '1, '1, '1));
      send_request(make_req(KIND_INSERT, 31'd5, 10'd3, 16'd100, 8'd1));
      send_request(make_req(KIND_INSERT, 31'd5, 10'd3, 16'd7, 8'd2));
      send_request(make_req(KIND_INSERT, 31'd5, 10'd1, 16'd200, 8'd3));
      send_request(make_req(KIND_INSERT, 31'd0, '1, '1, '1));
      send_request(make_req(KIND_INSERT, '1, 10'd0, 16'd0, 8'd0));
      send_request(make_req(KIND_INSERT, '1, '1, '1, '1));
      send_request(make_req(KIND_INSERT, 31'd2, 10'd3, 16'd1, 8'd9));
      send_request(make_req(KIND_LOOKUP, '0, 10'd3, '0, '0));
      send_request(make_req(KIND_LOOKUP, '1, 10'd0, '1, '1));
      send_request(make_req(KIND_LOOKUP, '0, '1, '0, '0));
      send_request(make_req(KIND_REMOVE, '0, 10'd3, '0, '0));
      send_request(make_req(KIND_LOOKUP, '0, 10'd3, '0, '0));
      send_request(make_req(KIND_UNUSED, '0, '0, '0, '0));
      send_request(make_req(KIND_LOOKUP, '0, 10'd512, '0, '0));
      send_request(make_req(KIND_REMOVE, '0, '1, '0, '0));
      send_request(make_req(KIND_REMOVE, '0, '1, '0, '0));
      send_request(make_req(KIND_LOOKUP, '0, 10'd0, '0, '0));

      // random: insert-heavy phases run the store up to full, drain phases
      // empty it again, so occupancy sweeps its whole range repeatedly
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet      = (n >= RANDOM_ITEMS - CALM_ITEMS);
         insert_pct = ((n / PHASE_LEN) % 2 == 0) ? 75 : 30;
         send_request(random_request(insert_pct));
      end
      req_chan.valid <= 1'b0;

      // drain: every response in, then room for any stray one
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
